FILE: design/chse_pkg.sv
// package for the cubic hermite spline evaluator
// shared constants and payload types; no dependencies
package chse_pkg;

  localparam int unsigned MaxPoints = 256;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned CountW    = 9;
  localparam int unsigned IndexW    = 8;
  localparam int unsigned ParamW    = 24;
  localparam int unsigned DataW     = 32;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    logic                     operation;
    logic [IndexW-1:0]        point_index;
    logic signed [DataW-1:0]  pos_x;
    logic signed [DataW-1:0]  pos_y;
    logic signed [DataW-1:0]  pos_z;
    logic signed [DataW-1:0]  tan_x;
    logic signed [DataW-1:0]  tan_y;
    logic signed [DataW-1:0]  tan_z;
    logic [ParamW-1:0]        param_t;
  } in_beat_t;

  typedef struct packed {
    logic signed [DataW-1:0] out_pos_x;
    logic signed [DataW-1:0] out_pos_y;
    logic signed [DataW-1:0] out_pos_z;
    logic signed [DataW-1:0] out_vel_x;
    logic signed [DataW-1:0] out_vel_y;
    logic signed [DataW-1:0] out_vel_z;
  } out_beat_t;

  // one stored setpoint row: position and tangent, x y z
  typedef struct packed {
    logic signed [DataW-1:0] px;
    logic signed [DataW-1:0] py;
    logic signed [DataW-1:0] pz;
    logic signed [DataW-1:0] mx;
    logic signed [DataW-1:0] my;
    logic signed [DataW-1:0] mz;
  } point_t;

endpackage

FILE: design/chse_if.sv
// valid/ready channel carrying one payload beat
// depends on nothing; payload type given as a type parameter
interface chse_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/chse_store.sv
// setpoint table: two banks (even and odd rows) so one query reads both
// ends of a segment together; depends on chse_pkg
module chse_store #(
  parameter int unsigned MaxPoints = chse_pkg::MaxPoints,
  localparam int unsigned AddrW = $clog2(MaxPoints),
  localparam int unsigned BankW = (AddrW > 1) ? AddrW - 1 : 1
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  chse_pkg::point_t     wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_seg_i,
  output chse_pkg::point_t     rd_p0_o,
  output chse_pkg::point_t     rd_p1_o
);
  localparam int unsigned Rows = (MaxPoints + 1) / 2;

  chse_pkg::point_t mem_even [Rows];
  chse_pkg::point_t mem_odd  [Rows];

  logic [BankW-1:0] even_addr, odd_addr;
  logic [AddrW:0]   seg_next;
  logic             seg_odd_q;
  chse_pkg::point_t rd_even_q, rd_odd_q;

  // segment s reads rows s and s+1; one lands in each bank
  // the last segment is at most MaxPoints-2, so s+1 never reaches the top bit
  assign seg_next  = {1'b0, rd_seg_i} + 1'b1;
  assign even_addr = rd_seg_i[0] ? seg_next[AddrW-1:1] : rd_seg_i[AddrW-1:1];
  assign odd_addr  = rd_seg_i[AddrW-1:1];

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_addr_i[0]) begin
      mem_even[wr_addr_i[AddrW-1:1]] <= wr_data_i;
    end
    if (wr_en_i && wr_addr_i[0]) begin
      mem_odd[wr_addr_i[AddrW-1:1]] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_even_q <= mem_even[even_addr];
      rd_odd_q  <= mem_odd[odd_addr];
      seg_odd_q <= rd_seg_i[0];
    end
  end

  assign rd_p0_o = seg_odd_q ? rd_odd_q : rd_even_q;
  assign rd_p1_o = seg_odd_q ? rd_even_q : rd_odd_q;
endmodule

FILE: design/chse_basis.sv
// hermite basis and derivative weights from the local fraction, two stages
// depends on chse_pkg
module chse_basis #(
  parameter int unsigned FracBits = chse_pkg::FracBits,
  localparam int unsigned UW = FracBits + 1,
  localparam int unsigned BW = FracBits + 5
) (
  input  logic                 clk_i,
  input  logic                 en1_i,
  input  logic                 en2_i,
  input  logic [UW-1:0]        u_i,
  output logic signed [BW-1:0] h_o [4],
  output logic signed [BW-1:0] d_o [4]
);
  localparam logic [2*UW-1:0] Half = (2*UW)'(1) << (FracBits - 1);
  localparam logic signed [BW-1:0] One = BW'(1) << FracBits;

  logic [2*UW-1:0] sq, cu;
  logic [UW-1:0]   u1_q, u2_q, u2_d;
  logic [UW-1:0]   u3;
  logic signed [BW-1:0] su, su2, su3;

  assign sq   = u_i * u_i + Half;
  assign u2_d = sq[FracBits +: UW];

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      u1_q <= u_i;
      u2_q <= u2_d;
    end
  end

  assign cu  = u2_q * u1_q + Half;
  assign u3  = cu[FracBits +: UW];
  assign su  = BW'(u1_q);
  assign su2 = BW'(u2_q);
  assign su3 = BW'(u3);

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      h_o[0] <= BW'(2 * su3 - 3 * su2 + One);
      h_o[1] <= BW'(su3 - 2 * su2 + su);
      h_o[2] <= BW'(3 * su2 - 2 * su3);
      h_o[3] <= BW'(su3 - su2);
      d_o[0] <= BW'(6 * su2 - 6 * su);
      d_o[1] <= BW'(3 * su2 - 4 * su + One);
      d_o[2] <= BW'(6 * su - 6 * su2);
      d_o[3] <= BW'(3 * su2 - 2 * su);
    end
  end
endmodule

FILE: design/chse_dot.sv
// one channel: four weight times value products, sum, round and saturate
// three register stages; depends on chse_pkg
module chse_dot #(
  parameter int unsigned FracBits = chse_pkg::FracBits,
  localparam int unsigned BW = FracBits + 5,
  localparam int unsigned DW = chse_pkg::DataW,
  localparam int unsigned PW = BW + DW,
  localparam int unsigned SW = PW + 2
) (
  input  logic                 clk_i,
  input  logic                 en_p_i,
  input  logic                 en_s_i,
  input  logic                 en_o_i,
  input  logic signed [BW-1:0] w_i [4],
  input  logic signed [DW-1:0] v_i [4],
  output logic signed [DW-1:0] res_o
);
  localparam logic signed [SW-1:0] Half = SW'(1) << (FracBits - 1);
  localparam logic signed [SW-1:0] MaxV = SW'(32'sh7fffffff);
  localparam logic signed [SW-1:0] MinV = -(SW'(32'sh7fffffff)) - SW'(1);

  logic signed [PW-1:0] prod_q [4];
  logic signed [SW-1:0] sum_q, rnd, shr;

  always_ff @(posedge clk_i) begin
    if (en_p_i) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= PW'(w_i[k]) * PW'(v_i[k]);
      end
    end
    if (en_s_i) begin
      sum_q <= SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]) + SW'(prod_q[3]);
    end
  end

  // arithmetic shift is floor, so add half first: ties go up
  assign rnd = sum_q + Half;
  assign shr = rnd >>> FracBits;

  always_ff @(posedge clk_i) begin
    if (en_o_i) begin
      if (shr > MaxV) begin
        res_o <= 32'sh7fffffff;
      end else if (shr < MinV) begin
        res_o <= 32'sh80000000;
      end else begin
        res_o <= shr[DW-1:0];
      end
    end
  end
endmodule

FILE: design/cubic_hermite_spline_eval.sv
// cubic hermite spline evaluator: setpoint table and query pipeline
// five register stages from the accepting edge to the output register
// throughput: one beat per cycle (write or query); a held result freezes the pipe
// write beats fill a table row and give no result
// reset: control clears at once, point_count goes to 2; the table stays
// undefined and needs no clearing pass
module cubic_hermite_spline_eval #(
  parameter int unsigned MaxPoints = chse_pkg::MaxPoints,
  parameter int unsigned FracBits  = chse_pkg::FracBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [chse_pkg::CountW-1:0] cfg_wdata_i,
  chse_if.sink                        in_if,
  chse_if.source                      out_if
);
  localparam int unsigned AddrW = $clog2(MaxPoints);
  localparam int unsigned UW    = FracBits + 1;
  localparam int unsigned BW    = FracBits + 5;
  localparam int unsigned DW    = chse_pkg::DataW;
  localparam int unsigned TW    = chse_pkg::ParamW;
  localparam int unsigned Depth = 5;
  localparam int unsigned CntW  = $clog2(Depth + 2);

  // pipeline: s0 table read + u^2, s1 u^3 + weights + data align,
  // s2 products, s3 sum, s4 round/saturate to the output register

  logic [chse_pkg::CountW-1:0] count_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= chse_pkg::CountW'(2);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // effective point count, at least 2 and clamped to the table
  logic [AddrW:0] n_eff;
  always_comb begin
    if (count_q < chse_pkg::CountW'(2)) begin
      n_eff = (AddrW+1)'(2);
    end else if (32'(count_q) > MaxPoints) begin
      n_eff = (AddrW+1)'(MaxPoints);
    end else begin
      n_eff = (AddrW+1)'(count_q);
    end
  end

  // global stall: a result held at the output freezes every stage and
  // closes the input, so nothing in flight is lost or overwritten
  logic            stall;
  logic [Depth-1:0] vld_q;
  logic             out_vld_q;
  logic [CntW-1:0]  inflight;
  logic             acc, qry, wr;

  assign stall = out_vld_q && !out_if.ready;
  assign in_if.ready = !stall;
  assign acc = in_if.valid && in_if.ready;
  assign qry = acc && (in_if.data.operation == chse_pkg::OP_QUERY);
  assign wr  = acc && (in_if.data.operation == chse_pkg::OP_WRITE);

  // all stages advance together when not stalled
  logic adv;
  assign adv = !stall;

  // clamp t and split it
  logic [TW+AddrW:0] t_ext, tmax;
  logic [TW+AddrW:0] t_cl;
  logic [AddrW:0]    seg_raw;
  logic [AddrW-1:0]  seg;
  logic [UW-1:0]     u0;
  assign t_ext = (TW+AddrW+1)'(in_if.data.param_t);
  assign tmax  = (TW+AddrW+1)'(n_eff - 1'b1) << FracBits;
  assign t_cl  = (t_ext > tmax) ? tmax : t_ext;
  assign seg_raw = t_cl[FracBits +: AddrW+1];
  always_comb begin
    if (seg_raw >= n_eff - 1'b1) begin
      // final endpoint: last segment at fraction one
      seg = AddrW'(n_eff - (AddrW+1)'(2));
      u0  = UW'(1) << FracBits;
    end else begin
      seg = seg_raw[AddrW-1:0];
      u0  = UW'(t_cl[FracBits-1:0]);
    end
  end

  chse_pkg::point_t wdat, p0, p1;
  assign wdat = '{px: in_if.data.pos_x, py: in_if.data.pos_y, pz: in_if.data.pos_z,
                  mx: in_if.data.tan_x, my: in_if.data.tan_y, mz: in_if.data.tan_z};

  logic wr_ok;
  assign wr_ok = wr && (32'(in_if.data.point_index) < MaxPoints);

  // reads are registered in the table, so a write followed by a query
  // at the next cycle sees the new row: write and read never collide
  // on a row at the same edge for ordered traffic
  chse_store #(.MaxPoints(MaxPoints)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_ok),
    .wr_addr_i (AddrW'(in_if.data.point_index)),
    .wr_data_i (wdat),
    .rd_en_i   (adv),
    .rd_seg_i  (seg),
    .rd_p0_o   (p0),
    .rd_p1_o   (p1)
  );

  logic signed [BW-1:0] h [4], d [4];
  chse_basis #(.FracBits(FracBits)) u_basis (
    .clk_i (clk_i),
    .en1_i (adv),
    .en2_i (adv),
    .u_i   (u0),
    .h_o   (h),
    .d_o   (d)
  );

  // points wait one stage to line up with the weights
  chse_pkg::point_t p0_q, p1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_q <= p0;
      p1_q <= p1;
    end
  end

  // weights registered after stage 1; products at stage 2
  logic signed [DW-1:0] vx [4], vy [4], vz [4];
  assign vx = '{p0_q.px, p0_q.mx, p1_q.px, p1_q.mx};
  assign vy = '{p0_q.py, p0_q.my, p1_q.py, p1_q.my};
  assign vz = '{p0_q.pz, p0_q.mz, p1_q.pz, p1_q.mz};

  chse_pkg::out_beat_t res;
  chse_dot #(.FracBits(FracBits)) u_px (.clk_i(clk_i), .en_p_i(adv), .en_s_i(adv),
    .en_o_i(adv), .w_i(h), .v_i(vx), .res_o(res.out_pos_x));
  chse_dot #(.FracBits(FracBits)) u_py (.clk_i(clk_i), .en_p_i(adv), .en_s_i(adv),
    .en_o_i(adv), .w_i(h), .v_i(vy), .res_o(res.out_pos_y));
  chse_dot #(.FracBits(FracBits)) u_pz (.clk_i(clk_i), .en_p_i(adv), .en_s_i(adv),
    .en_o_i(adv), .w_i(h), .v_i(vz), .res_o(res.out_pos_z));
  chse_dot #(.FracBits(FracBits)) u_vx (.clk_i(clk_i), .en_p_i(adv), .en_s_i(adv),
    .en_o_i(adv), .w_i(d), .v_i(vx), .res_o(res.out_vel_x));
  chse_dot #(.FracBits(FracBits)) u_vy (.clk_i(clk_i), .en_p_i(adv), .en_s_i(adv),
    .en_o_i(adv), .w_i(d), .v_i(vy), .res_o(res.out_vel_y));
  chse_dot #(.FracBits(FracBits)) u_vz (.clk_i(clk_i), .en_p_i(adv), .en_s_i(adv),
    .en_o_i(adv), .w_i(d), .v_i(vz), .res_o(res.out_vel_z));

  // valid pipe: s0 read, s1 weights, s2 prod, s3 sum, s4 output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], qry};
    end
  end
  assign out_vld_q = vld_q[Depth-1];

  assign out_if.valid = out_vld_q;
  assign out_if.data  = res;

  always_comb begin
    inflight = '0;
    for (int k = 0; k < Depth; k++) begin
      inflight = inflight + CntW'(vld_q[k]);
    end
  end

  // a stalled pipe takes no beat
  a_no_acc_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> !acc) else $error("beat taken while output stalled");
  // a held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> out_vld_q && $stable(res)) else $error("result changed while held");
  // never more queries in flight than stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight <= CntW'(Depth)) else $error("pipeline overfilled");
endmodule

FILE: tb/sv/cubic_hermite_spline_eval_tb.sv
// testbench for the cubic hermite spline evaluator
// depends on chse_pkg, chse_if and the cubic_hermite_spline_eval design
`timescale 1ns / 100ps

module cubic_hermite_spline_eval_tb;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [chse_pkg::CountW-1:0] cfg_wdata_i;

  chse_if #(.payload_t(chse_pkg::in_beat_t))  in_ch  ();
  chse_if #(.payload_t(chse_pkg::out_beat_t)) out_ch ();

  cubic_hermite_spline_eval u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 20;

  // shadow of the table and of point_count
  logic signed [chse_pkg::DataW-1:0] shadow_pos [chse_pkg::MaxPoints*3];
  logic signed [chse_pkg::DataW-1:0] shadow_tan [chse_pkg::MaxPoints*3];
  bit written [chse_pkg::MaxPoints];
  logic [chse_pkg::CountW-1:0] shadow_count;

  chse_pkg::in_beat_t  pending_beats [$];
  chse_pkg::out_beat_t curve_expected [$];

  int unsigned cycle_cnt;
  int unsigned mismatches;
  int unsigned queries_seen;
  int unsigned writes_sent;
  bit          quiet_mode;   // no idling in the last part
  bit          hold_rx;      // long receiver hold-off
  int unsigned tx_idle;
  int unsigned rx_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // add a beat at the tail of the pending queue
  function automatic void queue_beat(input chse_pkg::in_beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // round to nearest, ties up, then saturate to 32 bits
  function automatic logic signed [chse_pkg::DataW-1:0] round_sat(input longint acc);
    longint r;
    r = (acc + (64'sd1 <<< (chse_pkg::FracBits - 1))) >>> chse_pkg::FracBits;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[chse_pkg::DataW-1:0];
  endfunction

  // hermite evaluation on the shadow table
  function automatic chse_pkg::out_beat_t eval_curve(
    input logic [chse_pkg::ParamW-1:0] t_in);
    longint one, n, t, tmax, seg, u, u2, u3, ap, av;
    longint h[4];
    longint d[4];
    longint p0, m0, p1, m1;
    longint res_p[3];
    longint res_v[3];
    chse_pkg::out_beat_t o;
    one = 64'sd1 <<< chse_pkg::FracBits;
    n = shadow_count;
    if (n < 2) n = 2;
    if (n > chse_pkg::MaxPoints) n = chse_pkg::MaxPoints;
    t = t_in;
    tmax = (n - 1) <<< chse_pkg::FracBits;
    if (t > tmax) t = tmax;
    seg = t >>> chse_pkg::FracBits;
    u = t & (one - 1);
    if (seg >= n - 1) begin
      seg = n - 2;
      u = one;
    end
    u2 = (u * u + one / 2) >>> chse_pkg::FracBits;
    u3 = (u2 * u + one / 2) >>> chse_pkg::FracBits;
    h[0] = 2 * u3 - 3 * u2 + one;
    h[1] = u3 - 2 * u2 + u;
    h[2] = -2 * u3 + 3 * u2;
    h[3] = u3 - u2;
    d[0] = 6 * u2 - 6 * u;
    d[1] = 3 * u2 - 4 * u + one;
    d[2] = -6 * u2 + 6 * u;
    d[3] = 3 * u2 - 2 * u;
    for (int c = 0; c < 3; c++) begin
      p0 = shadow_pos[seg * 3 + c];
      m0 = shadow_tan[seg * 3 + c];
      p1 = shadow_pos[(seg + 1) * 3 + c];
      m1 = shadow_tan[(seg + 1) * 3 + c];
      ap = h[0] * p0 + h[1] * m0 + h[2] * p1 + h[3] * m1;
      av = d[0] * p0 + d[1] * m0 + d[2] * p1 + d[3] * m1;
      res_p[c] = round_sat(ap);
      res_v[c] = round_sat(av);
    end
    o.out_pos_x = res_p[0][chse_pkg::DataW-1:0];
    o.out_pos_y = res_p[1][chse_pkg::DataW-1:0];
    o.out_pos_z = res_p[2][chse_pkg::DataW-1:0];
    o.out_vel_x = res_v[0][chse_pkg::DataW-1:0];
    o.out_vel_y = res_v[1][chse_pkg::DataW-1:0];
    o.out_vel_z = res_v[2][chse_pkg::DataW-1:0];
    return o;
  endfunction

  // update shadow state for one accepted beat
  function automatic void apply_beat(input chse_pkg::in_beat_t b);
    int unsigned s;
    if (b.operation == chse_pkg::OP_WRITE) begin
      s = b.point_index;
      writes_sent = writes_sent + 1;
      if (s < chse_pkg::MaxPoints) begin
        shadow_pos[s*3+0] = b.pos_x;
        shadow_pos[s*3+1] = b.pos_y;
        shadow_pos[s*3+2] = b.pos_z;
        shadow_tan[s*3+0] = b.tan_x;
        shadow_tan[s*3+1] = b.tan_y;
        shadow_tan[s*3+2] = b.tan_z;
      end
    end else begin
      curve_expected.insert(curve_expected.size(), eval_curve(b.param_t));
    end
  endfunction

  // driver: feeds beats from pending_beats with random idle bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      tx_idle     <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_beat(in_ch.data);
        void'(pending_beats.pop_front());
      end
      if (tx_idle != 0) begin
        tx_idle <= tx_idle - 1;
        in_ch.valid <= 1'b0;
      end else if (!(in_ch.valid && !in_ch.ready)) begin
        // previous beat gone (or none): choose the next step
        if (!quiet_mode && $urandom_range(0, 9) == 0) begin
          tx_idle <= $urandom_range(1, 7) - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_beats[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_idle      <= 0;
    end else if (hold_rx) begin
      out_ch.ready <= 1'b0;
    end else if (rx_idle != 0) begin
      rx_idle <= rx_idle - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
      rx_idle <= $urandom_range(1, 7) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    chse_pkg::out_beat_t want;
    chse_pkg::out_beat_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      queries_seen <= queries_seen + 1;
      if (curve_expected.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = curve_expected.pop_front();
        if (got !== want) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch at cycle %0d: expected %p got %p", cycle_cnt, want, got);
        end
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [chse_pkg::DataW-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom();
    endcase
  endfunction

  function automatic chse_pkg::in_beat_t make_write(input int unsigned slot,
                                                    input bit extreme);
    chse_pkg::in_beat_t b;
    b.operation   = chse_pkg::OP_WRITE;
    b.point_index = chse_pkg::IndexW'(slot);
    b.pos_x = extreme ? 32'sh7fffffff : rand_word();
    b.pos_y = extreme ? 32'sh80000000 : rand_word();
    b.pos_z = rand_word();
    b.tan_x = extreme ? 32'sh80000000 : rand_word();
    b.tan_y = extreme ? 32'sh7fffffff : rand_word();
    b.tan_z = rand_word();
    b.param_t = chse_pkg::ParamW'($urandom());
    return b;
  endfunction

  function automatic chse_pkg::in_beat_t make_query(
    input logic [chse_pkg::ParamW-1:0] t);
    chse_pkg::in_beat_t b;
    b = make_write($urandom_range(0, 255), 1'b0);
    b.operation = chse_pkg::OP_QUERY;
    b.param_t   = t;
    return b;
  endfunction

  // wait until sent and all results back, plus pipeline drain
  task automatic wait_idle();
    while (pending_beats.size() != 0 || curve_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_count(input int unsigned n);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= chse_pkg::CountW'(n);
    shadow_count = chse_pkg::CountW'(n);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one phase: fill the rows in use (so reads stay on written rows), then traffic
  task automatic run_phase(input int unsigned cnt, input int unsigned nbeats);
    int unsigned n;
    int unsigned r;
    logic [chse_pkg::ParamW-1:0] tmax;
    n = (cnt < 2) ? 2 : ((cnt > chse_pkg::MaxPoints) ? chse_pkg::MaxPoints : cnt);
    set_count(cnt);
    for (int unsigned i = 0; i < n; i++) begin
      if (!written[i]) begin
        queue_beat(make_write(i, 1'b0));
        written[i] = 1'b1;
      end
    end
    tmax = chse_pkg::ParamW'((n - 1) << chse_pkg::FracBits);
    for (int unsigned k = 0; k < nbeats; k++) begin
      r = $urandom_range(0, 9);
      if (r < 2)
        queue_beat(make_write($urandom_range(0, n - 1), 1'b0));
      else if (r < 3)
        queue_beat(make_query(chse_pkg::ParamW'($urandom())));
      else if (r < 4)
        queue_beat(make_query(chse_pkg::ParamW'(tmax - $urandom_range(0, 1))));
      else
        queue_beat(make_query(chse_pkg::ParamW'($urandom_range(0, tmax))));
    end
    wait_idle();
  endtask

  initial begin
    int unsigned hold_len;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cycle_cnt = 0;
    mismatches = 0;
    queries_seen = 0;
    writes_sent = 0;
    quiet_mode = 1'b0;
    hold_rx = 1'b0;
    shadow_count = 2;
    for (int i = 0; i < chse_pkg::MaxPoints * 3; i++) begin
      shadow_pos[i] = '0;
      shadow_tan[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset count of two, extreme rows, ends, out of range t
    written[0] = 1'b1;
    written[1] = 1'b1;
    queue_beat(make_write(0, 1'b1));
    queue_beat(make_write(1, 1'b1));
    queue_beat(make_query(24'h000000));
    queue_beat(make_query(24'h008000));
    queue_beat(make_query(24'h00ffff));
    queue_beat(make_query(24'h010000));
    queue_beat(make_query(24'hffffff));
    queue_beat(make_write(255, 1'b1));
    queue_beat(make_write(0, 1'b0));
    queue_beat(make_query(24'h000001));
    written[255] = 1'b1;
    wait_idle();

    // count register extremes, including below 2 and above the table size
    run_phase(0, 20);
    run_phase(1, 20);
    run_phase(511, 40);

    // long receiver hold-off while the sender keeps offering beats
    hold_rx = 1'b1;
    run_phase_fill: begin
      set_count(8);
      for (int k = 0; k < 60; k++)
        queue_beat(make_query(chse_pkg::ParamW'($urandom_range(0,
                                                   7 << chse_pkg::FracBits))));
      hold_len = 300;
      while (hold_len != 0) begin
        @(posedge clk_i);
        hold_len--;
      end
      hold_rx = 1'b0;
      wait_idle();
    end

    for (int p = 0; p < 7; p++)
      run_phase($urandom_range(2, 16), 150);
    run_phase(256, 120);
    run_phase(2, 60);

    quiet_mode = 1'b1;
    run_phase($urandom_range(3, 40), 150);

    $display("covered %0d query results and %0d table writes over point counts",
             queries_seen, writes_sent);
    $display("from 0 to 511, with idle bursts, a long output stall and endpoint clamping");
    if (mismatches == 0 && curve_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: cubic_hermite_spline_eval.f
design/chse_pkg.sv
design/chse_if.sv
design/chse_store.sv
design/chse_basis.sv
design/chse_dot.sv
design/cubic_hermite_spline_eval.sv
tb/sv/cubic_hermite_spline_eval_tb.sv
